/* src/cst_pkg.sv */
// Shared types and constants for the comment stripper.
`timescale 1ns / 1ps

package cst_pkg;

  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharSQuote = 8'h27;
  localparam logic [7:0] CharDQuote = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       empty;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* src/cst_scan.sv */
// Scanner mode register and per-byte decode into up to two output words.
`timescale 1ns / 1ps

module cst_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output cst_pkg::push_t push_o
);

  localparam logic [3:0] ModeCode   = 4'd0;
  localparam logic [3:0] ModeSlash  = 4'd1;
  localparam logic [3:0] ModeLine   = 4'd2;
  localparam logic [3:0] ModeBlock  = 4'd3;
  localparam logic [3:0] ModeBstar  = 4'd4;
  localparam logic [3:0] ModeStr    = 4'd5;
  localparam logic [3:0] ModeStrEsc = 4'd6;
  localparam logic [3:0] ModeChr    = 4'd7;
  localparam logic [3:0] ModeChrEsc = 4'd8;

  logic [3:0] mode_q, mode_d;
  logic [3:0] nxt;
  logic [1:0] n;
  logic [7:0] b0, b1;
  logic       e0, l0, l1;

  always_comb begin
    nxt = mode_q;
    n   = 2'd0;
    b0  = 8'h00;
    b1  = 8'h00;
    e0  = 1'b0;
    l0  = 1'b0;
    l1  = 1'b0;
    unique case (mode_q)
      ModeSlash: begin
        if (byte_i == cst_pkg::CharSlash) begin
          nxt = ModeLine;
        end else if (byte_i == cst_pkg::CharStar) begin
          nxt = ModeBlock;
        end else begin
          n  = 2'd2;
          b0 = cst_pkg::CharSlash;
          b1 = byte_i;
          if (byte_i == cst_pkg::CharDQuote) nxt = ModeStr;
          else if (byte_i == cst_pkg::CharSQuote) nxt = ModeChr;
          else nxt = ModeCode;
        end
      end
      ModeLine: begin
        if (byte_i == cst_pkg::CharNl) begin
          n   = 2'd1;
          b0  = byte_i;
          nxt = ModeCode;
        end
      end
      ModeBlock: begin
        nxt = (byte_i == cst_pkg::CharStar) ? ModeBstar : ModeBlock;
      end
      ModeBstar: begin
        if (byte_i == cst_pkg::CharSlash) nxt = ModeCode;
        else if (byte_i == cst_pkg::CharStar) nxt = ModeBstar;
        else nxt = ModeBlock;
      end
      ModeStr: begin
        n  = 2'd1;
        b0 = byte_i;
        if (byte_i == cst_pkg::CharDQuote || byte_i == cst_pkg::CharNl) nxt = ModeCode;
        else if (byte_i == cst_pkg::CharBslash) nxt = ModeStrEsc;
        else nxt = ModeStr;
      end
      ModeStrEsc: begin
        n   = 2'd1;
        b0  = byte_i;
        nxt = ModeStr;
      end
      ModeChr: begin
        n  = 2'd1;
        b0 = byte_i;
        if (byte_i == cst_pkg::CharSQuote || byte_i == cst_pkg::CharNl) nxt = ModeCode;
        else if (byte_i == cst_pkg::CharBslash) nxt = ModeChrEsc;
        else nxt = ModeChr;
      end
      ModeChrEsc: begin
        n   = 2'd1;
        b0  = byte_i;
        nxt = ModeChr;
      end
      default: begin
        if (byte_i == cst_pkg::CharSlash) begin
          nxt = ModeSlash;
        end else begin
          n  = 2'd1;
          b0 = byte_i;
          if (byte_i == cst_pkg::CharDQuote) nxt = ModeStr;
          else if (byte_i == cst_pkg::CharSQuote) nxt = ModeChr;
          else nxt = ModeCode;
        end
      end
    endcase

    // flush a held slash and mark the final word of the text
    if (last_i) begin
      if (nxt == ModeSlash) begin
        n  = 2'd1;
        b0 = cst_pkg::CharSlash;
      end
      priority if (n == 2'd0) begin
        n  = 2'd1;
        e0 = 1'b1;
        l0 = 1'b1;
      end else if (n == 2'd1) begin
        l0 = 1'b1;
      end else begin
        l1 = 1'b1;
      end
      nxt = ModeCode;
    end
  end

  assign mode_d = accept_i ? nxt : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCode;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign push_o.cnt      = accept_i ? n : 2'd0;
  assign push_o.r0.data  = b0;
  assign push_o.r0.empty = e0;
  assign push_o.r0.last  = l0;
  assign push_o.r1.data  = b1;
  assign push_o.r1.empty = 1'b0;
  assign push_o.r1.last  = l1;

  a_last_returns_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> mode_q == ModeCode)
    else $error("mode not back to code after final byte");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |-> push_o.cnt != 2'd0)
    else $error("final byte produced no word");

endmodule

/* src/cst_outq.sv */
// Output queue taking up to two words per cycle and sending one per cycle while ready_i is high.
`timescale 1ns / 1ps

module cst_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cst_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output cst_pkg::res_t  res_o
);

  cst_pkg::res_t                mem_q [cst_pkg::QDepth];
  logic [cst_pkg::PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [cst_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign room_o  = cnt_q <= cst_pkg::CntW'(cst_pkg::QDepth - 2);
  assign res_o   = mem_q[rd_q];

  assign wr_d  = wr_q + cst_pkg::PtrW'(push_i.cnt);
  assign rd_d  = rd_q + cst_pkg::PtrW'(pop);
  assign cnt_d = cnt_q + cst_pkg::CntW'(push_i.cnt) - cst_pkg::CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + cst_pkg::PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("push into full queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + cst_pkg::CntW'($past(push_i.cnt))
                      - cst_pkg::CntW'($past(pop)))
    else $error("queue count out of step");

endmodule

/* src/c_comment_stripper_top.sv */
// Top level of the C/C++ comment stripper.
//
// Input stream: one source byte per word on s_axis, tlast on the final byte
// of a text. Output stream: the kept bytes on m_axis, tlast on the final word
// of the text; tuser set means the word carries no byte, only the end mark
// (a text whose final byte kept nothing).
// Each accepted byte yields zero, one or two words (two when a held slash
// turns out not to open a comment). A word is written into the output
// queue as its byte is accepted and leaves on m_axis from that queue.
// Throughput: one byte per cycle while results leave at one per cycle; a
// byte that makes two words puts one extra word into the queue, which the
// four-entry output queue absorbs. s_axis_tready drops when fewer than two
// queue entries are free.
// Reset: scanner returns to plain code mode and the queue empties.
// Stall: when m_axis_tready is low the queue holds its words and fills,
// then s_axis_tready falls; nothing is lost or repeated.
`timescale 1ns / 1ps

module c_comment_stripper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] out_empty
  output logic       m_axis_tlast
);

  cst_pkg::push_t push;
  cst_pkg::res_t  res;
  logic           room;
  logic           accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  cst_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push)
  );

  cst_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.empty;
  assign m_axis_tlast = res.last;

endmodule

/* tb/sv/tb_c_comment_stripper_top.sv */
// Self-checking stream testbench for the C/C++ comment stripper top level.
`timescale 1ns / 1ps

module tb_c_comment_stripper_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 800;
  localparam string CodeChars = "ab_x1;(){}= +-<>#\t\n*";
  localparam string BodyChars = "ab */\\\"'\n";

  typedef enum logic [3:0] {
    ScCode, ScSlash, ScLine, ScBlock, ScBStar, ScStr, ScStrEsc, ScChr, ScChrEsc
  } scan_e;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain;
  } src_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  src_item_t      src_q[$];
  cst_pkg::res_t  kept_q[$];
  scan_e          scan_st = ScCode;
  int             bytes_sent = 0;
  int             errors = 0;
  int             cycles = 0;
  int             hold_cnt = 0;
  bit             stall_done = 1'b0;
  logic           calm;

  assign calm = (bytes_sent >= 550) && (bytes_sent < 700);

  c_comment_stripper_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic cst_pkg::res_t kept_word(logic [7:0] b);
    cst_pkg::res_t r;
    r.data  = b;
    r.empty = 1'b0;
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic strip_byte(input logic [7:0] b, input logic lst);
    cst_pkg::res_t step_q[$];
    scan_e         nxt;
    bit            as_code;
    cst_pkg::res_t r;
    as_code = 1'b0;
    nxt = ScCode;
    case (scan_st)
      ScSlash: begin
        if (b == cst_pkg::CharSlash) nxt = ScLine;
        else if (b == cst_pkg::CharStar) nxt = ScBlock;
        else begin
          step_q.push_back(kept_word(cst_pkg::CharSlash));
          as_code = 1'b1;
        end
      end
      ScLine: begin
        if (b == cst_pkg::CharNl) begin
          step_q.push_back(kept_word(b));
          nxt = ScCode;
        end else begin
          nxt = ScLine;
        end
      end
      ScBlock: nxt = (b == cst_pkg::CharStar) ? ScBStar : ScBlock;
      ScBStar: begin
        if (b == cst_pkg::CharSlash) nxt = ScCode;
        else if (b == cst_pkg::CharStar) nxt = ScBStar;
        else nxt = ScBlock;
      end
      ScStr: begin
        step_q.push_back(kept_word(b));
        if (b == cst_pkg::CharDQuote || b == cst_pkg::CharNl) nxt = ScCode;
        else if (b == cst_pkg::CharBslash) nxt = ScStrEsc;
        else nxt = ScStr;
      end
      ScStrEsc: begin
        step_q.push_back(kept_word(b));
        nxt = ScStr;
      end
      ScChr: begin
        step_q.push_back(kept_word(b));
        if (b == cst_pkg::CharSQuote || b == cst_pkg::CharNl) nxt = ScCode;
        else if (b == cst_pkg::CharBslash) nxt = ScChrEsc;
        else nxt = ScChr;
      end
      ScChrEsc: begin
        step_q.push_back(kept_word(b));
        nxt = ScChr;
      end
      default: as_code = 1'b1;
    endcase
    if (as_code) begin
      if (b == cst_pkg::CharSlash) begin
        nxt = ScSlash;
      end else begin
        step_q.push_back(kept_word(b));
        if (b == cst_pkg::CharDQuote) nxt = ScStr;
        else if (b == cst_pkg::CharSQuote) nxt = ScChr;
        else nxt = ScCode;
      end
    end
    if (lst) begin
      if (nxt == ScSlash) step_q.push_back(kept_word(cst_pkg::CharSlash));
      if (step_q.size() == 0) begin
        r.data  = 8'h00;
        r.empty = 1'b1;
        r.last  = 1'b1;
        step_q.push_back(r);
      end else begin
        step_q[step_q.size() - 1].last = 1'b1;
      end
      nxt = ScCode;
    end
    scan_st = nxt;
    foreach (step_q[i]) kept_q.push_back(step_q[i]);
  endtask

  task automatic queue_text(input logic [7:0] txt[$], input bit hold);
    src_item_t it;
    foreach (txt[i]) begin
      it.b     = txt[i];
      it.last  = (i == txt.size() - 1);
      it.drain = hold && (i == 0);
      src_q.push_back(it);
    end
  endtask

  task automatic queue_str(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_text(txt, 1'b0);
  endtask

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic gen_text(input bit hold);
    logic [7:0] txt[$];
    int         target;
    int         r;
    int         k;
    target = ($urandom_range(19) == 0) ? 1 : $urandom_range(40, 4);
    while (txt.size() < target) begin
      r = $urandom_range(99);
      if (r < 30) begin
        k = $urandom_range(4, 1);
        repeat (k) txt.push_back(pick(CodeChars));
      end else if (r < 42) begin
        txt.push_back(cst_pkg::CharSlash);
        txt.push_back(cst_pkg::CharSlash);
        k = $urandom_range(6);
        repeat (k) txt.push_back(pick(BodyChars));
        if ($urandom_range(9) != 0) txt.push_back(cst_pkg::CharNl);
      end else if (r < 56) begin
        txt.push_back(cst_pkg::CharSlash);
        txt.push_back(cst_pkg::CharStar);
        k = $urandom_range(8);
        repeat (k) txt.push_back(pick(BodyChars));
        if ($urandom_range(9) != 0) begin
          txt.push_back(cst_pkg::CharStar);
          txt.push_back(cst_pkg::CharSlash);
        end
      end else if (r < 68) begin
        txt.push_back(cst_pkg::CharDQuote);
        k = $urandom_range(6);
        repeat (k) begin
          if ($urandom_range(4) == 0) begin
            txt.push_back(cst_pkg::CharBslash);
            txt.push_back(8'($urandom_range(255)));
          end else begin
            txt.push_back(pick(BodyChars));
          end
        end
        txt.push_back(($urandom_range(6) != 0) ? cst_pkg::CharDQuote : cst_pkg::CharNl);
      end else if (r < 77) begin
        txt.push_back(cst_pkg::CharSQuote);
        if ($urandom_range(9) < 3) txt.push_back(cst_pkg::CharBslash);
        txt.push_back(8'($urandom_range(255)));
        txt.push_back(cst_pkg::CharSQuote);
      end else if (r < 85) begin
        txt.push_back(cst_pkg::CharSlash);
      end else begin
        txt.push_back(8'($urandom_range(255)));
      end
    end
    queue_text(txt, hold);
  endtask

  // Feed the stream from the pending queue; predict each accepted byte.
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    src_item_t it;
    bit        busy;
    bit        offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        strip_byte(s_axis_tdata, s_axis_tlast);
        bytes_sent <= bytes_sent + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        offer = 1'b0;
        if (src_q.size() > 0) begin
          if (src_q[0].drain) begin
            if (kept_q.size() == 0) src_q[0].drain = 1'b0;
          end else if (calm || $urandom_range(99) >= 8) begin
            offer = 1'b1;
          end
        end
        if (offer) begin
          it = src_q.pop_front();
          s_axis_tdata <= it.b;
          s_axis_tlast <= it.last;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // Check each output word against the oldest prediction; pace tready.
  always @(posedge clk_i or negedge rst_ni) begin : check_p
    cst_pkg::res_t got;
    cst_pkg::res_t want;
    logic          rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      stall_done    <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data  = m_axis_tdata;
        got.empty = m_axis_tuser;
        got.last  = m_axis_tlast;
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual data=%h empty=%b last=%b",
                   $time, got.data, got.empty, got.last);
          errors++;
        end else begin
          want = kept_q.pop_front();
          if (got.data !== want.data || got.empty !== want.empty ||
              got.last !== want.last) begin
            $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b (data/empty/last)",
                     $time, want.data, want.empty, want.last,
                     got.data, got.empty, got.last);
            errors++;
          end
        end
      end
      if (!stall_done && bytes_sent >= 200) begin
        hold_cnt   <= 300;
        stall_done <= 1'b1;
        rdy = 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        rdy = 1'b0;
      end else begin
        rdy = calm || ($urandom_range(99) >= 8);
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** c_comment_stripper_top: FAILED **");
      $finish;
    end
  end

  initial begin : main_p
    logic [7:0] txt[$];
    int         queued;
    bit         held;
    queue_str("/b");
    queue_str("//c\n");
    queue_str("/**/");
    queue_str("\"/\\\"\"");
    queue_str("'\\''");
    txt = '{8'h00, 8'hFF, cst_pkg::CharSlash};
    queue_text(txt, 1'b0);
    queue_str("/*/");
    queue_str("\"\n");
    queued = src_q.size();
    held = 1'b0;
    while (src_q.size() - queued < RandBytes) begin
      gen_text(!held && (src_q.size() >= 450));
      if (src_q.size() >= 450) held = 1'b1;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (src_q.size() != 0 || s_axis_tvalid || kept_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("** c_comment_stripper_top: PASSED **");
    end else begin
      $display("** c_comment_stripper_top: FAILED **");
    end
    $finish;
  end

endmodule
